// File: hw/rtl/sgfm_pkg.sv
// Shared types and constants for the sparse-grid first-moment core.
// Holds the microcode word layout, the control/status bundles and fixed widths.
// No dependencies.
package sgfm_pkg;

    localparam int LEVEL_MAX_DEFAULT = 30;

    localparam int LEVEL_W = 5;
    localparam int INDEX_W = 30;
    localparam int BOUND_W = 32;
    localparam int FIX_W   = 64;
    localparam int HALF_W  = 32;
    localparam int ACC_W   = 2 * FIX_W;
    localparam int EXP_W   = 7;
    localparam int PC_W    = 5;

    // quotient bits per division step, and steps for a full word
    localparam int DIV_DIGIT_W = 8;
    localparam int DIV_STEPS   = FIX_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [FIX_W-1:0] ONE_Q48 = 64'h0001_0000_0000_0000;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_T0,
        OP_LOAD_T1,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MUL_HH,
        OP_SCALE,
        OP_DIV3,
        OP_ACC_TERM,
        OP_LOAD_PF,
        OP_LOAD_CP,
        OP_ROUND48,
        OP_ROUND24,
        OP_ADD_SUM,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_WAIT_IN,
        BR_NO_DIV,
        BR_DIV_MORE,
        BR_NOT_LAST_DIM,
        BR_NOT_LAST_PT,
        BR_OUT_FREE
    } t_br;

    typedef struct packed {
        t_op             op;
        t_br             br;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        logic d3;
        logic div_last;
        logic last_dim;
        logic last_pt;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/sparse_grid_first_moment_modlinear_core.sv
// The microprogram handles one item at a time: a new item is taken only once the
// program is back at its idle step. Edge indices add the divide-by-three loop on
// the width term; the last dimension of a point adds the coefficient steps and the
// last point adds the emit step. One shared 32x32 multiplier serves all products.
// Reset (synchronous, active low): product 1.0, sum 0, no saturation, no result.
module sparse_grid_first_moment_modlinear_core import sgfm_pkg::*; #(
    parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel: one word per grid point and dimension
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LEVEL_W-1:0]        i_level,
    input  logic [INDEX_W-1:0]        i_index,
    input  logic signed [BOUND_W-1:0] i_lower_bound,
    input  logic signed [BOUND_W-1:0] i_upper_bound,
    input  logic signed [BOUND_W-1:0] i_coefficient,
    input  logic                      i_last_dimension,
    input  logic                      i_last_point,
    // output channel: one word per grid
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FIX_W-1:0]   o_moment,
    output logic                      o_saturated
);

    // The sequencer steps through a short microprogram; each control word
    // selects one datapath operation and a branch condition. The datapath
    // reports back the few flags the branches need.
    t_ctrl ctrl;
    t_stat stat;

    // Fetch, branch and handshake on the input side. Ready is high only on the
    // idle step; take the word there and start the program.
    sgfm_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_ready (o_in_ready)
    );

    // Per item:
    //   - build the two factor terms: magnitude times multiplier, scale by a
    //     power of two, divide by three for edge indices, round and add;
    //   - multiply the running product by the factor (four partial products);
    //   - on the last dimension, multiply by the coefficient and add into the
    //     saturating sum, then return the product to 1.0;
    //   - on the last point, hold in the emit step until the output register is
    //     free, load it, and clear the grid state.
    // The output register parts the two channels: a result waiting there does
    // not block the next items until another result is due.
    sgfm_datapath #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_level          (i_level),
        .i_index          (i_index),
        .i_lower_bound    (i_lower_bound),
        .i_upper_bound    (i_upper_bound),
        .i_coefficient    (i_coefficient),
        .i_last_dimension (i_last_dimension),
        .i_last_point     (i_last_point),
        .i_out_ready      (i_out_ready),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_moment         (o_moment),
        .o_saturated      (o_saturated)
    );

    // An accepted word starts the program: the block is busy right after.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.accept |=> !o_in_ready)
        else $error("input still ready after a word was taken");

    // The division loop only runs for terms with a denominator of three.
    a_div_only_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_DIV3) |-> stat.d3)
        else $error("division step on a term without a third");

    // A result appears only out of the emit step.
    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.op == OP_EMIT))
        else $error("result shown without an emit step");

    // Emit waits while the output register still holds an untaken result.
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((ctrl.op == OP_EMIT) && !stat.out_free) |=> (ctrl.op == OP_EMIT))
        else $error("emit step left while output was blocked");

endmodule

// File: hw/rtl/sgfm_ucode_rom.sv
// Microprogram table of the sparse-grid first-moment core.
// Maps a step address to one control word. Depends on sgfm_pkg.
module sgfm_ucode_rom import sgfm_pkg::*; (
    input  logic [PC_W-1:0] i_pc,
    output t_uword          o_word
);

    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_DIV_T0   = 5'd4;
    localparam logic [PC_W-1:0] PC_ACC_T0   = 5'd5;
    localparam logic [PC_W-1:0] PC_DIV_T1   = 5'd9;
    localparam logic [PC_W-1:0] PC_ACC_T1   = 5'd10;
    localparam logic [PC_W-1:0] PC_PT_CHECK = 5'd22;

    function automatic t_uword uw(t_op op, t_br br, logic [PC_W-1:0] tgt);
        t_uword w;
        w.op     = op;
        w.br     = br;
        w.target = tgt;
        return w;
    endfunction

    always_comb begin
        case (i_pc)
            5'd0:    o_word = uw(OP_NOP,      BR_WAIT_IN,      PC_IDLE);
            // width term
            5'd1:    o_word = uw(OP_LOAD_T0,  BR_NEXT,         PC_IDLE);
            5'd2:    o_word = uw(OP_MUL_LL,   BR_NEXT,         PC_IDLE);
            5'd3:    o_word = uw(OP_SCALE,    BR_NO_DIV,       PC_ACC_T0);
            5'd4:    o_word = uw(OP_DIV3,     BR_DIV_MORE,     PC_DIV_T0);
            5'd5:    o_word = uw(OP_ACC_TERM, BR_NEXT,         PC_IDLE);
            // lower-bound term
            5'd6:    o_word = uw(OP_LOAD_T1,  BR_NEXT,         PC_IDLE);
            5'd7:    o_word = uw(OP_MUL_LL,   BR_NEXT,         PC_IDLE);
            5'd8:    o_word = uw(OP_SCALE,    BR_NO_DIV,       PC_ACC_T1);
            5'd9:    o_word = uw(OP_DIV3,     BR_DIV_MORE,     PC_DIV_T1);
            5'd10:   o_word = uw(OP_ACC_TERM, BR_NEXT,         PC_IDLE);
            // product times factor
            5'd11:   o_word = uw(OP_LOAD_PF,  BR_NEXT,         PC_IDLE);
            5'd12:   o_word = uw(OP_MUL_LL,   BR_NEXT,         PC_IDLE);
            5'd13:   o_word = uw(OP_MUL_LH,   BR_NEXT,         PC_IDLE);
            5'd14:   o_word = uw(OP_MUL_HL,   BR_NEXT,         PC_IDLE);
            5'd15:   o_word = uw(OP_MUL_HH,   BR_NEXT,         PC_IDLE);
            5'd16:   o_word = uw(OP_ROUND48,  BR_NOT_LAST_DIM, PC_PT_CHECK);
            // coefficient times product, coefficient fits the low half
            5'd17:   o_word = uw(OP_LOAD_CP,  BR_NEXT,         PC_IDLE);
            5'd18:   o_word = uw(OP_MUL_LL,   BR_NEXT,         PC_IDLE);
            5'd19:   o_word = uw(OP_MUL_LH,   BR_NEXT,         PC_IDLE);
            5'd20:   o_word = uw(OP_ROUND24,  BR_NEXT,         PC_IDLE);
            5'd21:   o_word = uw(OP_ADD_SUM,  BR_NEXT,         PC_IDLE);
            5'd22:   o_word = uw(OP_NOP,      BR_NOT_LAST_PT,  PC_IDLE);
            5'd23:   o_word = uw(OP_EMIT,     BR_OUT_FREE,     PC_IDLE);
            default: o_word = uw(OP_NOP,      BR_JUMP,         PC_IDLE);
        endcase
    end

endmodule

// File: hw/rtl/sgfm_sequencer.sv
// Step counter and branch logic of the sparse-grid first-moment core.
// Reads sgfm_ucode_rom and drives the datapath op. Depends on sgfm_pkg.
module sgfm_sequencer import sgfm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_in_ready
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [PC_W-1:0] pc_inc;
    t_uword          word;

    sgfm_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_word (word)
    );

    always_comb begin
        pc_inc = r_pc + 1'b1;
        case (word.br)
            BR_NEXT:         n_pc = pc_inc;
            BR_JUMP:         n_pc = word.target;
            BR_WAIT_IN:      n_pc = i_in_valid ? pc_inc : r_pc;
            BR_NO_DIV:       n_pc = i_stat.d3 ? pc_inc : word.target;
            BR_DIV_MORE:     n_pc = i_stat.div_last ? pc_inc : word.target;
            BR_NOT_LAST_DIM: n_pc = i_stat.last_dim ? pc_inc : word.target;
            BR_NOT_LAST_PT:  n_pc = i_stat.last_pt ? pc_inc : word.target;
            BR_OUT_FREE:     n_pc = i_stat.out_free ? word.target : r_pc;
            default:         n_pc = word.target;
        endcase
    end

    assign o_in_ready    = (word.br == BR_WAIT_IN);
    assign o_ctrl.op     = word.op;
    assign o_ctrl.accept = (word.br == BR_WAIT_IN) && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hw/rtl/sgfm_datapath.sv
// Datapath of the sparse-grid first-moment core: input latch, 32x32 multiplier
// with 128-bit accumulator, term scaler, divide-by-three unit, rounding,
// saturating sum and output register. Depends on sgfm_pkg.
module sgfm_datapath import sgfm_pkg::*; #(
    parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl                     i_ctrl,
    input  logic [LEVEL_W-1:0]        i_level,
    input  logic [INDEX_W-1:0]        i_index,
    input  logic signed [BOUND_W-1:0] i_lower_bound,
    input  logic signed [BOUND_W-1:0] i_upper_bound,
    input  logic signed [BOUND_W-1:0] i_coefficient,
    input  logic                      i_last_dimension,
    input  logic                      i_last_point,
    input  logic                      i_out_ready,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    output logic signed [FIX_W-1:0]   o_moment,
    output logic                      o_saturated
);

    localparam int SH_P = 48;
    localparam int SH_C = 24;

    // latched item
    logic [LEVEL_W-1:0]        r_lev;
    logic [INDEX_W-1:0]        r_idx;
    logic signed [BOUND_W-1:0] r_lo;
    logic signed [BOUND_W:0]   r_w;
    logic signed [BOUND_W-1:0] r_coef;
    logic                      r_last_dim;
    logic                      r_last_pt;
    // arithmetic
    logic [FIX_W-1:0]          r_ma;
    logic [FIX_W-1:0]          r_mb;
    logic                      r_neg;
    logic [EXP_W-1:0]          r_e;
    logic                      r_d3;
    logic [ACC_W-1:0]          r_acc;
    logic [FIX_W-1:0]          r_y;
    logic [FIX_W-1:0]          r_q;
    logic [1:0]                r_rem;
    logic [DIV_CNT_W-1:0]      r_cnt;
    logic [FIX_W-1:0]          r_fac;
    // architectural state and output
    logic [FIX_W-1:0]          r_prod;
    logic [FIX_W-1:0]          r_sum;
    logic                      r_seen;
    logic                      r_out_valid;
    logic [FIX_W-1:0]          r_moment;
    logic                      r_out_sat;

    logic                 out_free;
    logic                 emit;
    logic [LEVEL_W-1:0]   lev_c;
    logic [INDEX_W-1:0]   in_mask;
    // term descriptor
    logic [INDEX_W-1:0]   lev_mask;
    logic                 is_l1;
    logic                 is_left;
    logic                 is_right;
    logic [EXP_W-1:0]     lev2;
    logic [EXP_W-1:0]     lev1;
    logic                 second;
    logic signed [BOUND_W:0] t_v;
    logic [BOUND_W:0]     t_vabs;
    logic [HALF_W-1:0]    t_mult;
    logic [EXP_W-1:0]     t_e;
    logic                 t_d3;
    // magnitudes
    logic [FIX_W-1:0]     prod_abs;
    logic [FIX_W-1:0]     fac_abs;
    logic [BOUND_W-1:0]   coef_abs;
    // multiplier
    logic [HALF_W-1:0]    a_half;
    logic [HALF_W-1:0]    b_half;
    logic [FIX_W-1:0]     pp;
    logic [ACC_W-1:0]     pp_sh;
    // scaler
    logic [5:0]           k;
    logic [EXP_W-1:0]     e_neg;
    logic [FIX_W+1:0]     x_round;
    logic [FIX_W-1:0]     y_left;
    logic [FIX_W-1:0]     y_right;
    logic [FIX_W-1:0]     y_val;
    // divide by three
    logic [1:0]           d_rem;
    logic [2:0]           d_r3;
    logic [FIX_W-1:0]     d_y;
    logic [DIV_DIGIT_W-1:0] d_qd;
    // term accumulate
    logic [FIX_W-1:0]     q_sel;
    logic [FIX_W-1:0]     q_signed;
    // rounding
    logic [FIX_W:0]       rnd_m;
    logic                 rnd_hi;
    logic [FIX_W:0]       rnd_lim;
    logic                 rnd_sat;
    logic [FIX_W-1:0]     rnd_mag;
    logic [FIX_W-1:0]     rnd_val;
    // saturating sum
    logic [FIX_W:0]       sum_ext;
    logic                 sum_ovf;
    logic [FIX_W-1:0]     sum_val;

    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = (i_ctrl.op == OP_EMIT) && out_free;

    // clamp level and keep the index bits below 2^level
    always_comb begin
        if (i_level == '0) begin
            lev_c = LEVEL_W'(1);
        end else if (i_level > LEVEL_W'(LEVEL_MAX)) begin
            lev_c = LEVEL_W'(LEVEL_MAX);
        end else begin
            lev_c = i_level;
        end
        in_mask = ~({INDEX_W{1'b1}} << lev_c);
    end

    // pick value, multiplier, exponent and denominator of the current term
    always_comb begin
        lev_mask = ~({INDEX_W{1'b1}} << r_lev);
        is_l1    = (r_lev == LEVEL_W'(1));
        is_left  = (r_idx == INDEX_W'(1));
        is_right = (r_idx == lev_mask);
        lev1     = {2'b00, r_lev};
        lev2     = {1'b0, r_lev, 1'b0};
        second   = (i_ctrl.op == OP_LOAD_T1);
        if (second) begin
            t_v    = {r_lo[BOUND_W-1], r_lo};
            t_mult = HALF_W'(1);
            t_d3   = 1'b0;
            if (is_l1) begin
                t_e = EXP_W'(24);
            end else if (is_left || is_right) begin
                t_e = EXP_W'(25) - lev1;
            end else begin
                t_e = EXP_W'(24) - lev1;
            end
        end else begin
            t_v = r_w;
            if (is_l1) begin
                t_mult = HALF_W'(1);
                t_e    = EXP_W'(23);
                t_d3   = 1'b0;
            end else if (is_left) begin
                t_mult = HALF_W'(1);
                t_e    = EXP_W'(26) - lev2;
                t_d3   = 1'b1;
            end else if (is_right) begin
                t_mult = (HALF_W'(3) << r_lev) - HALF_W'(2);
                t_e    = EXP_W'(25) - lev2;
                t_d3   = 1'b1;
            end else begin
                t_mult = HALF_W'(r_idx);
                t_e    = EXP_W'(24) - lev2;
                t_d3   = 1'b0;
            end
        end
        t_vabs = t_v[BOUND_W] ? (~t_v + 1'b1) : t_v;
    end

    always_comb begin
        prod_abs = r_prod[FIX_W-1] ? (~r_prod + 1'b1) : r_prod;
        fac_abs  = r_fac[FIX_W-1] ? (~r_fac + 1'b1) : r_fac;
        coef_abs = r_coef[BOUND_W-1] ? (~r_coef + 1'b1) : r_coef;
    end

    // one 32x32 partial product per step, placed by word offset
    always_comb begin
        a_half = ((i_ctrl.op == OP_MUL_HL) || (i_ctrl.op == OP_MUL_HH)) ?
                 r_ma[FIX_W-1:HALF_W] : r_ma[HALF_W-1:0];
        b_half = ((i_ctrl.op == OP_MUL_LH) || (i_ctrl.op == OP_MUL_HH)) ?
                 r_mb[FIX_W-1:HALF_W] : r_mb[HALF_W-1:0];
        pp     = a_half * b_half;
        case (i_ctrl.op)
            OP_MUL_LH, OP_MUL_HL: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
            OP_MUL_HH:            pp_sh = {pp, {FIX_W{1'b0}}};
            default:              pp_sh = {{FIX_W{1'b0}}, pp};
        endcase
    end

    // scale the magnitude by 2^e; for a third, bias so that a floor
    // division by three rounds to nearest
    always_comb begin
        e_neg   = EXP_W'(0) - r_e;
        k       = e_neg[5:0];
        y_left  = (r_acc[FIX_W-1:0] << r_e[5:0]) + FIX_W'(r_d3);
        x_round = {1'b0, r_acc[FIX_W-1:0], 1'b0} +
                  ((r_d3 ? (FIX_W+2)'(3) : (FIX_W+2)'(1)) << k);
        y_right = FIX_W'(x_round >> ({1'b0, k} + 7'd1));
        y_val   = r_e[EXP_W-1] ? y_right : y_left;
    end

    // long division by three, one digit of quotient bits per step
    always_comb begin
        d_rem = r_rem;
        d_y   = r_y;
        d_qd  = '0;
        d_r3  = '0;
        for (int j = 0; j < DIV_DIGIT_W; j++) begin
            d_r3 = {d_rem, d_y[FIX_W-1]};
            d_y  = d_y << 1;
            if (d_r3 >= 3'd3) begin
                d_rem = 2'(d_r3 - 3'd3);
                d_qd  = {d_qd[DIV_DIGIT_W-2:0], 1'b1};
            end else begin
                d_rem = d_r3[1:0];
                d_qd  = {d_qd[DIV_DIGIT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        q_sel    = r_d3 ? r_q : r_y;
        q_signed = r_neg ? (~q_sel + 1'b1) : q_sel;
    end

    // round to nearest, ties away from zero, then clamp the magnitude
    always_comb begin
        if (i_ctrl.op == OP_ROUND24) begin
            rnd_m  = {1'b0, r_acc[SH_C+FIX_W-1:SH_C]} + (FIX_W+1)'(r_acc[SH_C-1]);
            rnd_hi = |r_acc[ACC_W-1:SH_C+FIX_W];
        end else begin
            rnd_m  = {1'b0, r_acc[SH_P+FIX_W-1:SH_P]} + (FIX_W+1)'(r_acc[SH_P-1]);
            rnd_hi = |r_acc[ACC_W-1:SH_P+FIX_W];
        end
        rnd_lim = {2'b00, {(FIX_W-1){1'b1}}} + (FIX_W+1)'(r_neg);
        rnd_sat = rnd_hi || (rnd_m > rnd_lim);
        rnd_mag = rnd_sat ? rnd_lim[FIX_W-1:0] : rnd_m[FIX_W-1:0];
        rnd_val = r_neg ? (~rnd_mag + 1'b1) : rnd_mag;
    end

    always_comb begin
        sum_ext = {r_sum[FIX_W-1], r_sum} + {r_fac[FIX_W-1], r_fac};
        sum_ovf = (sum_ext[FIX_W] != sum_ext[FIX_W-1]);
        if (sum_ovf) begin
            sum_val = sum_ext[FIX_W] ? {1'b1, {(FIX_W-1){1'b0}}} :
                                       {1'b0, {(FIX_W-1){1'b1}}};
        end else begin
            sum_val = sum_ext[FIX_W-1:0];
        end
    end

    // running product, sum, sticky saturation and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod      <= ONE_Q48;
            r_sum       <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.op)
                OP_ROUND48: begin
                    r_prod <= rnd_val;
                    r_seen <= r_seen | rnd_sat;
                end
                OP_ROUND24: begin
                    r_seen <= r_seen | rnd_sat;
                end
                OP_ADD_SUM: begin
                    r_sum  <= sum_val;
                    r_prod <= ONE_Q48;
                    r_seen <= r_seen | sum_ovf;
                end
                OP_EMIT: begin
                    if (out_free) begin
                        r_prod      <= ONE_Q48;
                        r_sum       <= '0;
                        r_seen      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_lev      <= lev_c;
            r_idx      <= i_index & in_mask;
            r_lo       <= i_lower_bound;
            r_w        <= {i_upper_bound[BOUND_W-1], i_upper_bound} -
                          {i_lower_bound[BOUND_W-1], i_lower_bound};
            r_coef     <= i_coefficient;
            r_last_dim <= i_last_dimension;
            r_last_pt  <= i_last_point;
        end
        if (emit) begin
            r_moment  <= r_sum;
            r_out_sat <= r_seen;
        end
        case (i_ctrl.op)
            OP_LOAD_T0, OP_LOAD_T1: begin
                r_ma  <= {{(FIX_W-HALF_W){1'b0}}, t_vabs[HALF_W-1:0]};
                r_mb  <= {{(FIX_W-HALF_W){1'b0}}, t_mult};
                r_neg <= t_v[BOUND_W];
                r_e   <= t_e;
                r_d3  <= t_d3;
                r_acc <= '0;
                if (i_ctrl.op == OP_LOAD_T0) begin
                    r_fac <= '0;
                end
            end
            OP_MUL_LL, OP_MUL_LH, OP_MUL_HL, OP_MUL_HH: begin
                r_acc <= r_acc + pp_sh;
            end
            OP_SCALE: begin
                r_y   <= y_val;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV3: begin
                r_y   <= d_y;
                r_q   <= {r_q[FIX_W-DIV_DIGIT_W-1:0], d_qd};
                r_rem <= d_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_ACC_TERM: begin
                r_fac <= r_fac + q_signed;
            end
            OP_LOAD_PF: begin
                r_ma  <= prod_abs;
                r_mb  <= fac_abs;
                r_neg <= r_prod[FIX_W-1] ^ r_fac[FIX_W-1];
                r_acc <= '0;
            end
            OP_LOAD_CP: begin
                r_ma  <= {{(FIX_W-BOUND_W){1'b0}}, coef_abs};
                r_mb  <= prod_abs;
                r_neg <= r_coef[BOUND_W-1] ^ r_prod[FIX_W-1];
                r_acc <= '0;
            end
            OP_ROUND24: begin
                r_fac <= rnd_val;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.d3       = r_d3;
    assign o_stat.div_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.last_dim = r_last_dim;
    assign o_stat.last_pt  = r_last_pt;
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_moment    = r_moment;
    assign o_saturated = r_out_sat;

endmodule
